// File: sv/nndh_pkg.sv
// Shared types and constants of the nearest-neighbor distance histogram.
// Depends on nothing; cell, isqrt, top and test files use it by scoped names.
`default_nettype none

package nndh_pkg;

    localparam int BOX_BITS       = 15;
    localparam int ATOMS_CFG_BITS = 9;
    localparam int BW_BITS        = 16;
    localparam int BINS_CFG_BITS  = 7;
    localparam int BIN_IDX_BITS   = 6;
    localparam int CNT_BITS       = 32;
    localparam int SUM_BITS       = 48;
    localparam int NEAR_BITS      = 17;
    localparam int MAG_BITS       = 14;
    localparam int SQ_BITS        = 28;
    localparam int D2_BITS        = 30;
    localparam int ROOT_BITS      = 15;
    localparam int AXES           = 3;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATOMS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIN_W = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BINS  = 3'd5;

    // Marks that travel with one atom pair through the cell chain.
    typedef struct packed {
        logic valid;
        logic fin;
    } pair_tag_t;

    typedef logic [AXES-1:0][BOX_BITS-1:0] box_vec_t;

endpackage

`default_nettype wire

// File: sv/nndh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module nndh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/nndh_cell.sv
// One cell of the minimum-image chain: one restoring remainder step per axis.
// Depends on nndh_pkg.
`default_nettype none

module nndh_cell #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire nndh_pkg::box_vec_t                            box,
    input  wire nndh_pkg::pair_tag_t                           tag_in,
    input  wire logic [nndh_pkg::AXES-1:0][COORD_BITS-1:0]     abs_in,
    input  wire logic [nndh_pkg::AXES-1:0][nndh_pkg::BOX_BITS-1:0] rem_in,
    output nndh_pkg::pair_tag_t                                tag_out,
    output logic [nndh_pkg::AXES-1:0][COORD_BITS-1:0]          abs_out,
    output logic [nndh_pkg::AXES-1:0][nndh_pkg::BOX_BITS-1:0]  rem_out
);

    nndh_pkg::pair_tag_t tag_reg;
    logic [nndh_pkg::AXES-1:0][COORD_BITS-1:0]         abs_reg, abs_next;
    logic [nndh_pkg::AXES-1:0][nndh_pkg::BOX_BITS-1:0] rem_reg, rem_next;
    logic [nndh_pkg::AXES-1:0][nndh_pkg::BOX_BITS:0]   trial;

    // Shift the next magnitude bit into the partial remainder and subtract
    // the box length when it fits.
    always_comb
    begin
        for (int a = 0; a < nndh_pkg::AXES; a++)
        begin
            trial[a] = {rem_in[a], abs_in[a][COORD_BITS-1]};
            if (trial[a] >= {1'b0, box[a]})
            begin
                trial[a] = trial[a] - {1'b0, box[a]};
            end
            rem_next[a] = trial[a][nndh_pkg::BOX_BITS-1:0];
            abs_next[a] = abs_in[a] << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= abs_next;
        rem_reg <= rem_next;
    end

    assign tag_out = tag_reg;
    assign abs_out = abs_reg;
    assign rem_out = rem_reg;

endmodule

`default_nettype wire

// File: sv/nndh_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on nndh_pkg.
`default_nettype none

module nndh_isqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [nndh_pkg::D2_BITS-1:0]     value,
    output logic                                  done,
    output logic      [nndh_pkg::ROOT_BITS-1:0]   root
);

    localparam int W = nndh_pkg::D2_BITS;

    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] res_reg, res_next;
    logic [W-1:0] bit_reg, bit_next;
    logic         done_reg, done_next;
    logic [W-1:0] trial;

    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start)
        begin
            v_next   = value;
            res_next = '0;
            bit_next = W'(1) << (W - 2);
        end
        else if (bit_reg != '0)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = (bit_reg == W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg[nndh_pkg::ROOT_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/nearest_neighbor_distance_histogram.sv
// Nearest-neighbor distance histogram under the periodic minimum-image rule.
// Depends on nndh_pkg, nndh_ram, nndh_cell and nndh_isqrt.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// With mode low the item is one atom position; it is stored and busy stays
// low, except for the position that completes a frame. That one starts the
// frame pass, and busy stays high until it ends. For each atom j the pass
// reads all n stored positions, one per cycle, through a chain of COORD_BITS
// remainder cells per axis, then takes an iterative square root, checks the
// result against earlier nearest distances and, if none is equal, bins it by
// repeated subtraction. The one-pair-per-cycle sweep and the serial scan of
// earlier distances set the run time of a frame.
// With mode high the item is a report: bins 0 to bins_in_use-1 appear on
// consecutive cycles, each for one cycle with strobe high, the first one once
// the report state has read it into the output registers, last marking the
// final bin. Busy drops as the final bin shows. The receiver cannot stall;
// results are simply shown. Reset clears the histogram (by valid bits), the
// totals and the atom count, and sets the configuration to its defaults.
`default_nettype none

module nearest_neighbor_distance_histogram #(
    parameter int MAX_ATOMS  = 256,
    parameter int MAX_BINS   = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   mode,
    input  wire logic signed [COORD_BITS-1:0]           pos_x,
    input  wire logic signed [COORD_BITS-1:0]           pos_y,
    input  wire logic signed [COORD_BITS-1:0]           pos_z,
    input  wire logic                                   wr_en,
    input  wire logic [nndh_pkg::CFG_IDX_BITS-1:0]      wr_index,
    input  wire logic [nndh_pkg::CFG_DATA_BITS-1:0]     wr_data,
    output logic                                        strobe,
    output logic [nndh_pkg::BIN_IDX_BITS-1:0]           bin_index,
    output logic [nndh_pkg::CNT_BITS-1:0]               bin_count,
    output logic [nndh_pkg::CNT_BITS-1:0]               total_count,
    output logic [nndh_pkg::SUM_BITS-1:0]               distance_sum,
    output logic                                        last
);

    localparam int ATOM_BITS = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int N_BITS    = ATOM_BITS + 1;
    localparam int CMPW      = (N_BITS > nndh_pkg::ATOMS_CFG_BITS) ? N_BITS
                                                                   : nndh_pkg::ATOMS_CFG_BITS;
    localparam int HB        = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int POS_W     = nndh_pkg::AXES * COORD_BITS;
    localparam int BB        = nndh_pkg::BOX_BITS;
    localparam int NB_BITS   = nndh_pkg::BINS_CFG_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOADJ  = 4'd1;
    localparam logic [3:0] S_LATCHJ = 4'd2;
    localparam logic [3:0] S_SWEEP  = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_SQRT   = 4'd5;
    localparam logic [3:0] S_DEDUP  = 4'd6;
    localparam logic [3:0] S_BIN    = 4'd7;
    localparam logic [3:0] S_HRD    = 4'd8;
    localparam logic [3:0] S_HWR    = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_REPORT = 4'd11;

    // Configuration registers.
    logic [BB-1:0]                           box_x_reg, box_y_reg, box_z_reg;
    logic [nndh_pkg::ATOMS_CFG_BITS-1:0]     atoms_reg;
    logic [nndh_pkg::BW_BITS-1:0]            bin_w_reg;
    logic [NB_BITS-1:0]                      bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg <= 15'd2560;
            box_y_reg <= 15'd2560;
            box_z_reg <= 15'd2560;
            atoms_reg <= 9'd64;
            bin_w_reg <= 16'd64;
            bins_reg  <= 7'd64;
        end
        else if (wr_en)
        begin
            case (wr_index)
                nndh_pkg::REG_BOX_X: box_x_reg <= wr_data[BB-1:0];
                nndh_pkg::REG_BOX_Y: box_y_reg <= wr_data[BB-1:0];
                nndh_pkg::REG_BOX_Z: box_z_reg <= wr_data[BB-1:0];
                nndh_pkg::REG_ATOMS: atoms_reg <= wr_data[nndh_pkg::ATOMS_CFG_BITS-1:0];
                nndh_pkg::REG_BIN_W: bin_w_reg <= wr_data;
                nndh_pkg::REG_BINS:  bins_reg  <= wr_data[NB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings after clamping.
    nndh_pkg::box_vec_t             box_eff;
    logic [N_BITS-1:0]              n_eff;
    logic [CMPW-1:0]                atoms_w;
    logic [NB_BITS-1:0]             nb_eff;
    logic [nndh_pkg::BW_BITS-1:0]   bw_eff;

    always_comb
    begin
        box_eff[0] = (box_x_reg == '0) ? BB'(1) : box_x_reg;
        box_eff[1] = (box_y_reg == '0) ? BB'(1) : box_y_reg;
        box_eff[2] = (box_z_reg == '0) ? BB'(1) : box_z_reg;
        atoms_w    = CMPW'(atoms_reg);
        if (atoms_w < CMPW'(2))
        begin
            n_eff = N_BITS'(2);
        end
        else if (atoms_w > CMPW'(MAX_ATOMS))
        begin
            n_eff = N_BITS'(MAX_ATOMS);
        end
        else
        begin
            n_eff = N_BITS'(atoms_w);
        end
        if (bins_reg == '0)
        begin
            nb_eff = NB_BITS'(1);
        end
        else if (bins_reg > NB_BITS'(MAX_BINS))
        begin
            nb_eff = NB_BITS'(MAX_BINS);
        end
        else
        begin
            nb_eff = bins_reg;
        end
        bw_eff = (bin_w_reg == '0) ? 16'd1 : bin_w_reg;
    end

    // Control and datapath registers.
    logic [3:0]                       state_reg, state_next;
    logic [ATOM_BITS-1:0]             cnt_reg, cnt_next;
    logic [ATOM_BITS-1:0]             j_reg, j_next;
    logic [N_BITS-1:0]                k_reg, k_next;
    logic [N_BITS-1:0]                n_reg, n_next;
    logic [ATOM_BITS-1:0]             dk_reg, dk_next;
    logic                             dcmp_reg, dcmp_next;
    logic                             seen_reg, seen_next;
    logic [NB_BITS-1:0]               bin_reg, bin_next;
    logic [NB_BITS-1:0]               rp_reg, rp_next;
    logic                             rep_valid_reg, rep_valid_next;
    logic                             rep_last_reg, rep_last_next;
    logic [HB-1:0]                    rep_idx_reg, rep_idx_next;
    logic [nndh_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [nndh_pkg::SUM_BITS-1:0]    sum_reg, sum_next;
    logic [MAX_BINS-1:0]              hvalid_reg, hvalid_next;
    logic                             hv_rd_reg;
    logic [POS_W-1:0]                 pj_reg, pj_next;
    logic [nndh_pkg::D2_BITS-1:0]     best_reg, best_next;
    logic [nndh_pkg::NEAR_BITS-1:0]   d_reg, d_next;
    logic [nndh_pkg::NEAR_BITS-1:0]   rem_reg, rem_next;

    // Memories.
    logic                             pos_we;
    logic [ATOM_BITS-1:0]             pos_raddr;
    logic [POS_W-1:0]                 pos_rdata;
    logic                             near_we;
    logic [nndh_pkg::NEAR_BITS-1:0]   near_rdata;
    logic                             hist_we;
    logic [HB-1:0]                    hist_raddr;
    logic [nndh_pkg::CNT_BITS-1:0]    hist_rdata;
    logic [nndh_pkg::CNT_BITS-1:0]    hist_wdata;

    nndh_ram #(.WIDTH(POS_W), .DEPTH(MAX_ATOMS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (cnt_reg),
        .wdata ({pos_z, pos_y, pos_x}),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    nndh_ram #(.WIDTH(nndh_pkg::NEAR_BITS), .DEPTH(MAX_ATOMS)) u_near_ram (
        .clk   (clk),
        .we    (near_we),
        .waddr (j_reg),
        .wdata (d_next),
        .raddr (dk_reg),
        .rdata (near_rdata)
    );

    nndh_ram #(.WIDTH(nndh_pkg::CNT_BITS), .DEPTH(MAX_BINS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (bin_reg[HB-1:0]),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Pair pipeline: issue tag, difference stage, cell chain, fold, square.
    nndh_pkg::pair_tag_t tag0_reg, tag0_next, tag1_reg, tagf_reg, tagg_reg;
    logic [nndh_pkg::AXES-1:0][COORD_BITS-1:0]             abs1_reg, abs1_next;
    logic [nndh_pkg::AXES-1:0][nndh_pkg::MAG_BITS-1:0]     mag_reg, mag_next;
    logic [nndh_pkg::AXES-1:0][nndh_pkg::SQ_BITS-1:0]      sq_reg;
    logic signed [COORD_BITS:0]                            diff;
    logic [COORD_BITS:0]                                   diff_abs;
    logic [BB:0]                                           twice;
    logic [BB-1:0]                                         r_fin;
    logic [BB-1:0]                                         fold;
    logic [nndh_pkg::D2_BITS-1:0]                          d2;

    nndh_pkg::pair_tag_t                                   chain_tag [COORD_BITS+1];
    logic [nndh_pkg::AXES-1:0][COORD_BITS-1:0]             chain_abs [COORD_BITS+1];
    logic [nndh_pkg::AXES-1:0][BB-1:0]                     chain_rem [COORD_BITS+1];

    assign chain_tag[0] = tag1_reg;
    assign chain_abs[0] = abs1_reg;
    assign chain_rem[0] = '0;

    for (genvar c = 0; c < COORD_BITS; c++)
    begin : g_cell
        nndh_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .box     (box_eff),
            .tag_in  (chain_tag[c]),
            .abs_in  (chain_abs[c]),
            .rem_in  (chain_rem[c]),
            .tag_out (chain_tag[c+1]),
            .abs_out (chain_abs[c+1]),
            .rem_out (chain_rem[c+1])
        );
    end

    always_comb
    begin
        diff     = '0;
        diff_abs = '0;
        twice    = '0;
        r_fin    = '0;
        fold     = '0;
        for (int a = 0; a < nndh_pkg::AXES; a++)
        begin
            diff = $signed({pj_reg[a*COORD_BITS+COORD_BITS-1],
                            pj_reg[a*COORD_BITS +: COORD_BITS]})
                 - $signed({pos_rdata[a*COORD_BITS+COORD_BITS-1],
                            pos_rdata[a*COORD_BITS +: COORD_BITS]});
            diff_abs     = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
            abs1_next[a] = diff_abs[COORD_BITS-1:0];
            // Rounding the quotient up leaves the magnitude box minus remainder.
            r_fin = chain_rem[COORD_BITS][a];
            twice = {r_fin, 1'b0};
            fold  = (twice >= {1'b0, box_eff[a]}) ? (box_eff[a] - r_fin) : r_fin;
            mag_next[a] = fold[nndh_pkg::MAG_BITS-1:0];
        end
        d2 = nndh_pkg::D2_BITS'(sq_reg[0]) + nndh_pkg::D2_BITS'(sq_reg[1])
           + nndh_pkg::D2_BITS'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tagf_reg <= '0;
            tagg_reg <= '0;
        end
        else
        begin
            tag0_reg <= tag0_next;
            tag1_reg <= tag0_reg;
            tagf_reg <= chain_tag[COORD_BITS];
            tagg_reg <= tagf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abs1_reg <= abs1_next;
        mag_reg  <= mag_next;
        for (int a = 0; a < nndh_pkg::AXES; a++)
        begin
            sq_reg[a] <= mag_reg[a] * mag_reg[a];
        end
    end

    // Square root unit.
    logic                             sq_done;
    logic [nndh_pkg::ROOT_BITS-1:0]   sq_root;
    logic                             sq_start;

    nndh_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (best_next),
        .done  (sq_done),
        .root  (sq_root)
    );

    logic [N_BITS-1:0] cnt_inc;
    logic              dk_issue;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        dk_next        = dk_reg;
        dcmp_next      = 1'b0;
        seen_next      = seen_reg;
        bin_next       = bin_reg;
        rp_next        = rp_reg;
        rep_valid_next = 1'b0;
        rep_last_next  = rep_last_reg;
        rep_idx_next   = rep_idx_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        hvalid_next    = hvalid_reg;
        pj_next        = pj_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        best_next      = best_reg;
        tag0_next      = '0;
        pos_we         = 1'b0;
        near_we        = 1'b0;
        hist_we        = 1'b0;
        sq_start       = 1'b0;
        pos_raddr      = (state_reg == S_LOADJ) ? j_reg : k_reg[ATOM_BITS-1:0];
        hist_raddr     = (state_reg == S_REPORT) ? rp_reg[HB-1:0] : bin_reg[HB-1:0];
        hist_wdata     = (hv_rd_reg ? hist_rdata : '0) + 1'b1;
        cnt_inc        = N_BITS'(cnt_reg) + 1'b1;
        dk_issue       = (dk_reg != j_reg);

        if (tagg_reg.valid && (d2 < best_reg))
        begin
            best_next = d2;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        rp_next    = '0;
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        pos_we = 1'b1;
                        if (cnt_inc >= n_eff)
                        begin
                            n_next     = n_eff;
                            j_next     = '0;
                            cnt_next   = '0;
                            state_next = S_LOADJ;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[ATOM_BITS-1:0];
                        end
                    end
                end
            end
            S_LOADJ:
            begin
                state_next = S_LATCHJ;
            end
            S_LATCHJ:
            begin
                pj_next    = pos_rdata;
                best_next  = '1;
                k_next     = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                tag0_next.valid = (k_reg[ATOM_BITS-1:0] != j_reg);
                tag0_next.fin   = (k_reg == n_reg - 1'b1);
                k_next          = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (tagg_reg.fin)
                begin
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    d_next     = nndh_pkg::NEAR_BITS'(sq_root);
                    near_we    = 1'b1;
                    dk_next    = '0;
                    seen_next  = 1'b0;
                    state_next = S_DEDUP;
                end
            end
            S_DEDUP:
            begin
                // Reads of earlier nearest distances run one ahead of the compare.
                if (dk_issue)
                begin
                    dk_next   = dk_reg + 1'b1;
                    dcmp_next = 1'b1;
                end
                if (dcmp_reg && (near_rdata == d_reg))
                begin
                    seen_next = 1'b1;
                end
                if (!dk_issue && !dcmp_reg)
                begin
                    if (seen_reg)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        rem_next   = d_reg;
                        bin_next   = '0;
                        state_next = S_BIN;
                    end
                end
            end
            S_BIN:
            begin
                if ((rem_reg >= {1'b0, bw_eff}) && (bin_reg < nb_eff - 1'b1))
                begin
                    rem_next = rem_reg - {1'b0, bw_eff};
                    bin_next = bin_reg + 1'b1;
                end
                else
                begin
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                state_next = S_HWR;
            end
            S_HWR:
            begin
                hist_we                      = 1'b1;
                hvalid_next[bin_reg[HB-1:0]] = 1'b1;
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + nndh_pkg::SUM_BITS'(d_reg);
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (N_BITS'(j_reg) == n_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_LOADJ;
                end
            end
            S_REPORT:
            begin
                rep_valid_next = 1'b1;
                rep_idx_next   = rp_reg[HB-1:0];
                rep_last_next  = (rp_reg == nb_eff - 1'b1);
                rp_next        = rp_reg + 1'b1;
                if (rp_reg == nb_eff - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            dk_reg        <= '0;
            dcmp_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            bin_reg       <= '0;
            rp_reg        <= '0;
            rep_valid_reg <= 1'b0;
            rep_last_reg  <= 1'b0;
            rep_idx_reg   <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            hvalid_reg    <= '0;
            hv_rd_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            dk_reg        <= dk_next;
            dcmp_reg      <= dcmp_next;
            seen_reg      <= seen_next;
            bin_reg       <= bin_next;
            rp_reg        <= rp_next;
            rep_valid_reg <= rep_valid_next;
            rep_last_reg  <= rep_last_next;
            rep_idx_reg   <= rep_idx_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            hvalid_reg    <= hvalid_next;
            hv_rd_reg     <= hvalid_reg[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        pj_reg   <= pj_next;
        best_reg <= best_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = rep_valid_reg;
    assign bin_index    = nndh_pkg::BIN_IDX_BITS'(rep_idx_reg);
    assign bin_count    = hv_rd_reg ? hist_rdata : '0;
    assign total_count  = count_reg;
    assign distance_sum = sum_reg;
    assign last         = rep_last_reg;

endmodule

`default_nettype wire

// File: sv/nndh_checker.sv
// Port-level checks of the report sequence of the histogram block.
// Depends on nearest_neighbor_distance_histogram, to which it is bound.
`default_nettype none

module nndh_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       busy,
    input wire logic       strobe,
    input wire logic [5:0] bin_index,
    input wire logic       last
);

    // Bins of one report come on consecutive cycles, in order.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (bin_index == 6'($past(bin_index) + 6'd1)))
        else $error("report bins not contiguous");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result right after final bin");

    a_first_bin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> (bin_index == 6'd0))
        else $error("report does not start at bin zero");

    a_busy_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("block idle in the middle of a report");

endmodule

bind nearest_neighbor_distance_histogram nndh_checker u_nndh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .strobe    (strobe),
    .bin_index (bin_index),
    .last      (last)
);

`default_nettype wire

// File: test/nndh_checker.sv
// Checker for the nearest-neighbor distance histogram: watches the item,
// register and result ports, predicts every bin report and compares it.
// Depends on nndh_pkg for the register indexes and port widths.
`timescale 1ns / 100ps

module nndh_scoreboard (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic                                mode,
    input  wire logic signed [15:0]                  pos_x,
    input  wire logic signed [15:0]                  pos_y,
    input  wire logic signed [15:0]                  pos_z,
    input  wire logic                                wr_en,
    input  wire logic [nndh_pkg::CFG_IDX_BITS-1:0]   wr_index,
    input  wire logic [nndh_pkg::CFG_DATA_BITS-1:0]  wr_data,
    input  wire logic                                strobe,
    input  wire logic [nndh_pkg::BIN_IDX_BITS-1:0]   bin_index,
    input  wire logic [nndh_pkg::CNT_BITS-1:0]       bin_count,
    input  wire logic [nndh_pkg::CNT_BITS-1:0]       total_count,
    input  wire logic [nndh_pkg::SUM_BITS-1:0]       distance_sum,
    input  wire logic                                last,
    output int                                       fail_count,
    output int                                       pending
);

    localparam int ATOM_SLOTS = 256;
    localparam int BIN_SLOTS  = 64;

    typedef struct packed {
        logic [nndh_pkg::BIN_IDX_BITS-1:0] idx;
        logic [nndh_pkg::CNT_BITS-1:0]     cnt;
        logic [nndh_pkg::CNT_BITS-1:0]     total;
        logic [nndh_pkg::SUM_BITS-1:0]     sum;
        logic                              fin;
    } bin_report_t;

    bin_report_t report_q[$];

    logic [nndh_pkg::BOX_BITS-1:0]       box_len[3];
    logic [nndh_pkg::ATOMS_CFG_BITS-1:0] atoms_cfg;
    logic [nndh_pkg::BW_BITS-1:0]        width_cfg;
    logic [nndh_pkg::BINS_CFG_BITS-1:0]  bins_cfg;

    longint atom_pos[ATOM_SLOTS][3];
    longint nearest[ATOM_SLOTS];
    int     loaded;
    logic [nndh_pkg::CNT_BITS-1:0] hist[BIN_SLOTS];
    logic [nndh_pkg::CNT_BITS-1:0] counted;
    logic [nndh_pkg::SUM_BITS-1:0] dist_total;

    function automatic longint wrap_axis(longint d, longint box);
        longint a, q, r, res;
        if (box == 0) box = 1;
        a = d < 0 ? -d : d;
        q = a / box;
        r = a % box;
        // Quotient is rounded half away from zero.
        if (2 * r >= box) q++;
        res = a - q * box;
        return d < 0 ? -res : res;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint root, trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic int bins_eff();
        return bins_cfg == 0 ? 1 : (bins_cfg > BIN_SLOTS ? BIN_SLOTS : int'(bins_cfg));
    endfunction

    task automatic process_frame(int n);
        longint best, d2, dd;
        longint ax[3];
        longint bw, b;
        bit     seen;
        bw = width_cfg == 0 ? 1 : width_cfg;
        for (int j = 0; j < n; j++) begin
            best = -1;
            for (int k = 0; k < n; k++) begin
                if (j != k) begin
                    for (int a = 0; a < 3; a++)
                        ax[a] = wrap_axis(atom_pos[j][a] - atom_pos[k][a], box_len[a]);
                    d2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
                    if (best < 0 || d2 < best) best = d2;
                end
            end
            nearest[j] = int_sqrt(best);
        end
        // Each distinct nearest distance of the frame is counted once.
        for (int j = 0; j < n; j++) begin
            seen = 0;
            dd = nearest[j];
            for (int k = 0; k < j; k++)
                if (nearest[k] == dd) seen = 1;
            if (!seen) begin
                b = dd / bw;
                if (b >= bins_eff()) b = bins_eff() - 1;
                hist[b] = hist[b] + 1;
                counted = counted + 1;
                dist_total = dist_total + dd;
            end
        end
    endtask

    task automatic take_item();
        int n, slot;
        bin_report_t r;
        if (mode == 1'b0) begin
            n = atoms_cfg < 2 ? 2 : (atoms_cfg > ATOM_SLOTS ? ATOM_SLOTS : int'(atoms_cfg));
            slot = loaded % ATOM_SLOTS;
            atom_pos[slot][0] = pos_x;
            atom_pos[slot][1] = pos_y;
            atom_pos[slot][2] = pos_z;
            loaded = slot + 1;
            if (loaded >= n) begin
                process_frame(n);
                loaded = 0;
            end
        end
        else begin
            for (int i = 0; i < bins_eff(); i++) begin
                r.idx   = i[nndh_pkg::BIN_IDX_BITS-1:0];
                r.cnt   = hist[i];
                r.total = counted;
                r.sum   = dist_total;
                r.fin   = (i + 1 == bins_eff());
                report_q = {report_q, r};
            end
        end
    endtask

    task automatic check_result();
        bin_report_t want, got;
        got = '{bin_index, bin_count, total_count, distance_sum, last};
        if (report_q.size() == 0) begin
            $display("%0t: unexpected bin report: expected none, got %h", $time, got);
            fail_count++;
        end
        else begin
            want = report_q.pop_front();
            if (got.idx != want.idx || got.cnt != want.cnt || got.total != want.total ||
                got.sum != want.sum || got.fin != want.fin) begin
                $display("%0t: bin report mismatch: expected idx %0d cnt %0d total %0d",
                         $time, want.idx, want.cnt, want.total);
                $display("%0t:     expected sum %0d last %0d", $time, want.sum, want.fin);
                $display("%0t:     actual   idx %0d cnt %0d total %0d sum %0d last %0d",
                         $time, got.idx, got.cnt, got.total, got.sum, got.fin);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fail_count = 0;
            box_len    = '{15'd2560, 15'd2560, 15'd2560};
            atoms_cfg  = 9'd64;
            width_cfg  = 16'd64;
            bins_cfg   = 7'd64;
            loaded     = 0;
            counted    = '0;
            dist_total = '0;
            for (int i = 0; i < BIN_SLOTS; i++) hist[i] = '0;
            report_q.delete();
        end
        else begin
            if (strobe) check_result();
            if (wr_en) begin
                case (wr_index)
                    nndh_pkg::REG_BOX_X: box_len[0] = wr_data[nndh_pkg::BOX_BITS-1:0];
                    nndh_pkg::REG_BOX_Y: box_len[1] = wr_data[nndh_pkg::BOX_BITS-1:0];
                    nndh_pkg::REG_BOX_Z: box_len[2] = wr_data[nndh_pkg::BOX_BITS-1:0];
                    nndh_pkg::REG_ATOMS: atoms_cfg  = wr_data[nndh_pkg::ATOMS_CFG_BITS-1:0];
                    nndh_pkg::REG_BIN_W: width_cfg  = wr_data[nndh_pkg::BW_BITS-1:0];
                    nndh_pkg::REG_BINS:  bins_cfg   = wr_data[nndh_pkg::BINS_CFG_BITS-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) take_item();
        end
        pending = report_q.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the nearest-neighbor distance histogram: clock, reset,
// register writes and item stimulus. Depends on nndh_pkg, nndh_scoreboard and the histogram block.
`timescale 1ns / 100ps

module tb_top;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic mode = 0;
    logic signed [15:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic wr_en = 0;
    logic [nndh_pkg::CFG_IDX_BITS-1:0]  wr_index = '0;
    logic [nndh_pkg::CFG_DATA_BITS-1:0] wr_data = '0;
    logic busy, strobe, last;
    logic [nndh_pkg::BIN_IDX_BITS-1:0] bin_index;
    logic [nndh_pkg::CNT_BITS-1:0] bin_count, total_count;
    logic [nndh_pkg::SUM_BITS-1:0] distance_sum;
    int fail_count, pending;
    int sent;
    bit no_gaps;

    always #5 clk = ~clk;

    nearest_neighbor_distance_histogram u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .strobe(strobe), .bin_index(bin_index), .bin_count(bin_count),
        .total_count(total_count), .distance_sum(distance_sum), .last(last)
    );

    nndh_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .strobe(strobe), .bin_index(bin_index), .bin_count(bin_count),
        .total_count(total_count), .distance_sum(distance_sum), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    // Called at a rising edge; returns at the edge that took the item,
    // or after the idle gap that follows it.
    task automatic send_item(logic m, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        start <= 1'b1;
        mode  <= m;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do @(posedge clk); while (busy);
        sent++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_atom(int span);
        logic [15:0] c[3];
        for (int a = 0; a < 3; a++)
            c[a] = span == 0 ? 16'($urandom) : 16'($urandom_range(0, span));
        send_item(1'b0, c[0], c[1], c[2]);
    endtask

    task automatic send_report();
        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Waits out any frame pass and report still in progress.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (busy || pending != 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [nndh_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val[nndh_pkg::CFG_DATA_BITS-1:0];
        @(posedge clk);
    endtask

    task automatic write_done();
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_setup();
        int sel;
        sel = $urandom_range(0, 9);
        write_reg(nndh_pkg::REG_BOX_X,
                  sel == 0 ? 0 : (sel == 1 ? 32767 : $urandom_range(1, 32767)));
        write_reg(nndh_pkg::REG_BOX_Y, $urandom_range(1, 32767));
        write_reg(nndh_pkg::REG_BOX_Z, sel == 2 ? 1 : $urandom_range(1, 32767));
        write_reg(nndh_pkg::REG_ATOMS, $urandom_range(2, 12));
        write_reg(nndh_pkg::REG_BIN_W,
                  sel == 3 ? 0 : (sel == 4 ? 65535 : $urandom_range(1, 3000)));
        write_reg(nndh_pkg::REG_BINS,
                  sel == 5 ? 0 : (sel == 6 ? 127 : $urandom_range(1, 64)));
        write_done();
    endtask

    initial begin
        int n;
        int span;
        sent = 0;
        no_gaps = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: report on an empty histogram, then four positions of a reset-default frame.
        send_report();
        for (int i = 0; i < 4; i++) send_item(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
        settle();

        // Small frame with extreme coordinates and zero box length on x.
        write_reg(nndh_pkg::REG_BOX_X, 0);
        write_reg(nndh_pkg::REG_BOX_Y, 32767);
        write_reg(nndh_pkg::REG_BOX_Z, 1);
        write_reg(nndh_pkg::REG_ATOMS, 1);
        write_reg(nndh_pkg::REG_BIN_W, 0);
        write_reg(nndh_pkg::REG_BINS, 127);
        write_done();
        send_item(1'b0, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(1'b0, 16'h8000, 16'h7FFF, 16'h0001);
        send_report();
        settle();

        // Atom count lowered mid-frame after writing the largest value.
        write_reg(nndh_pkg::REG_BOX_X, 32767);
        write_reg(nndh_pkg::REG_ATOMS, 511);
        write_reg(nndh_pkg::REG_BIN_W, 65535);
        write_reg(nndh_pkg::REG_BINS, 0);
        write_done();
        for (int i = 0; i < 4; i++) send_atom(0);
        settle();
        write_reg(nndh_pkg::REG_ATOMS, 3);
        write_reg(nndh_pkg::REG_BIN_W, 16);
        write_reg(nndh_pkg::REG_BINS, 64);
        write_done();
        send_atom(0);
        send_report();
        settle();

        // Random phases of well-formed frames, with occasional reports.
        while (sent < 260) begin
            random_setup();
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                n = u_checker.atoms_cfg;
                span = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4000);
                for (int i = 0; i < n; i++) send_atom(span);
                if ($urandom_range(0, 2) != 0) send_report();
            end
            send_report();
            settle();
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
